// ===== rtl/bounded_list_insert_remove_engine_unit_defines.svh =====
// Assertion macros used by the list engine checker.
`ifndef BOUNDED_LIST_INSERT_REMOVE_ENGINE_UNIT_DEFINES_SVH
`define BOUNDED_LIST_INSERT_REMOVE_ENGINE_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define BLIRE_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("list engine check failed");

// Next-cycle implication, disabled while reset is high.
`define BLIRE_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("list engine check failed");

`endif

// ===== rtl/blire_pkg.sv =====
// Package: sizes, codes, result types and index helpers of the list engine.
package blire_pkg;

   localparam int DEPTH  = 32;
   localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W  = $clog2(DEPTH + 1);
   localparam int OP_W   = 3;
   localparam int VAL_W  = 32;
   localparam int ST_W   = 3;
   localparam int CNTF_W = 6;

   typedef logic [IDX_W-1:0] idx_type;
   typedef logic [CNT_W-1:0] cnt_type;

   localparam cnt_type DEPTH_CNT = CNT_W'(DEPTH);
   localparam idx_type IDX_LAST  = IDX_W'(DEPTH - 1);

   localparam logic [OP_W-1:0] OP_INS_FRONT = 3'd0;
   localparam logic [OP_W-1:0] OP_INS_BACK  = 3'd1;
   localparam logic [OP_W-1:0] OP_READ_ALL  = 3'd2;
   localparam logic [OP_W-1:0] OP_REMOVE    = 3'd3;
   localparam logic [OP_W-1:0] OP_CLEAR     = 3'd4;

   localparam logic [ST_W-1:0] ST_INSERTED = 3'd0;
   localparam logic [ST_W-1:0] ST_FULL     = 3'd1;
   localparam logic [ST_W-1:0] ST_EMPTY    = 3'd2;
   localparam logic [ST_W-1:0] ST_ENTRY    = 3'd3;
   localparam logic [ST_W-1:0] ST_REMOVED  = 3'd4;
   localparam logic [ST_W-1:0] ST_NOTFOUND = 3'd5;
   localparam logic [ST_W-1:0] ST_CLEARED  = 3'd6;

   typedef struct packed {
      logic [ST_W-1:0]         status;
      logic signed [VAL_W-1:0] entry_value;
      logic [CNTF_W-1:0]       removed_count;
      logic [CNTF_W-1:0]       list_size;
      logic                    last;
   } rsp_type;

   typedef struct packed {
      logic    load;
      rsp_type res;
   } rsp_push_type;

   // Ring position of list offset off; head and off are both below DEPTH.
   function automatic idx_type slot(idx_type head, cnt_type off);
      logic [CNT_W:0] sum;
      sum = (CNT_W+1)'(head) + (CNT_W+1)'(off);
      if (sum >= (CNT_W+1)'(DEPTH)) begin
         sum = sum - (CNT_W+1)'(DEPTH);
      end
      return sum[IDX_W-1:0];
   endfunction

   function automatic logic [CNTF_W-1:0] cnt_field(cnt_type c);
      return CNTF_W'(c);
   endfunction

endpackage

// ===== rtl/blire_ifs.sv =====
// Channel interfaces: request (opcode, value) and response.
interface blire_req_if;
   import blire_pkg::*;
   logic                    valid;
   logic                    ready;
   logic [OP_W-1:0]         opcode;
   logic signed [VAL_W-1:0] value;
   modport source (output valid, output opcode, output value, input ready);
   modport sink   (input valid, input opcode, input value, output ready);
endinterface

interface blire_rsp_if;
   import blire_pkg::*;
   logic                    valid;
   logic                    ready;
   logic [ST_W-1:0]         status;
   logic signed [VAL_W-1:0] entry_value;
   logic [CNTF_W-1:0]       removed_count;
   logic [CNTF_W-1:0]       list_size;
   logic                    last;
   modport source (output valid, output status, output entry_value, output removed_count,
                   output list_size, output last, input ready);
   modport sink   (input valid, input status, input entry_value, input removed_count,
                   input list_size, input last, output ready);
endinterface

// ===== rtl/bounded_list_insert_remove_engine_unit.sv =====
// Top level: bounded ring-store list engine with a one-port-in, one-port-out entry RAM.
//
//   channel   direction  payload                                          handshake
//   req_chan  in         opcode, value                                    valid/ready
//   rsp_chan  out        status, entry_value, removed_count, list_size,   valid/ready
//                        last
//
// One transaction at a time: ready is high only in idle.
// Insert, clear and status-only results are formed in S_EXEC and loaded into the response register.
// Read-out does one RAM read per entry and sends each entry from S_READ.
// Remove does one read, compare and compacting write per entry in S_SCAN, then reports from S_FIN.
// Response back-pressure stalls the sequencer; no clearing pass after reset.
module bounded_list_insert_remove_engine_unit (
   input  logic        clock,
   input  logic        reset,
   blire_req_if.sink   req_chan,
   blire_rsp_if.source rsp_chan
);
   import blire_pkg::*;

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_EXEC = 3'd1;
   localparam logic [2:0] S_READ = 3'd2;
   localparam logic [2:0] S_SCAN = 3'd3;
   localparam logic [2:0] S_FIN  = 3'd4;

   logic [2:0]              state_ff, state_in;
   logic [OP_W-1:0]         op_ff, op_in;
   logic signed [VAL_W-1:0] val_ff, val_in;
   idx_type                 head_ff, head_in;
   cnt_type                 count_ff, count_in;
   cnt_type                 idx_ff, idx_in;
   cnt_type                 kept_ff, kept_in;
   cnt_type                 idx_nx;
   cnt_type                 removed;
   idx_type                 new_head;

   logic signed [VAL_W-1:0] mem [DEPTH];
   logic signed [VAL_W-1:0] rdata_ff;
   logic                    mem_we, mem_re;
   idx_type                 mem_waddr, mem_raddr;
   logic signed [VAL_W-1:0] mem_wdata;

   rsp_push_type push;
   logic         can_load;

   assign req_chan.ready = (state_ff == S_IDLE);
   assign idx_nx         = idx_ff + 1'b1;
   assign removed        = count_ff - kept_ff;
   assign new_head       = (head_ff == '0) ? IDX_LAST : head_ff - 1'b1;

   always_comb begin
      state_in  = state_ff;
      op_in     = op_ff;
      val_in    = val_ff;
      head_in   = head_ff;
      count_in  = count_ff;
      idx_in    = idx_ff;
      kept_in   = kept_ff;
      mem_we    = 1'b0;
      mem_waddr = slot(head_ff, kept_ff);
      mem_wdata = rdata_ff;
      mem_re    = 1'b0;
      mem_raddr = slot(head_ff, idx_nx);
      push.load              = 1'b0;
      push.res.status        = ST_EMPTY;
      push.res.entry_value   = '0;
      push.res.removed_count = '0;
      push.res.list_size     = cnt_field(count_ff);
      push.res.last          = 1'b1;

      case (state_ff)
         S_IDLE: begin
            if (req_chan.valid) begin
               op_in    = req_chan.opcode;
               val_in   = req_chan.value;
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            case (op_ff)
               OP_INS_FRONT, OP_INS_BACK: begin
                  if (can_load) begin
                     push.load = 1'b1;
                     state_in  = S_IDLE;
                     if (count_ff >= DEPTH_CNT) begin
                        push.res.status = ST_FULL;
                     end else begin
                        mem_we    = 1'b1;
                        mem_wdata = val_ff;
                        if (op_ff == OP_INS_FRONT) begin
                           head_in   = new_head;
                           mem_waddr = new_head;
                        end else begin
                           mem_waddr = slot(head_ff, count_ff);
                        end
                        count_in           = count_ff + 1'b1;
                        push.res.status    = ST_INSERTED;
                        push.res.list_size = cnt_field(count_ff + 1'b1);
                     end
                  end
               end
               OP_READ_ALL, OP_REMOVE: begin
                  if (count_ff == '0) begin
                     if (can_load) begin
                        push.load = 1'b1;
                        state_in  = S_IDLE;
                     end
                  end else begin
                     mem_re    = 1'b1;
                     mem_raddr = head_ff;
                     idx_in    = '0;
                     kept_in   = '0;
                     state_in  = (op_ff == OP_READ_ALL) ? S_READ : S_SCAN;
                  end
               end
               OP_CLEAR: begin
                  if (can_load) begin
                     push.load = 1'b1;
                     state_in  = S_IDLE;
                     if (count_ff != '0) begin
                        count_in           = '0;
                        head_in            = '0;
                        push.res.status    = ST_CLEARED;
                        push.res.list_size = '0;
                     end
                  end
               end
               default: begin
                  state_in = S_IDLE;
               end
            endcase
         end
         S_READ: begin
            // rdata_ff holds entry idx_ff; the next read issues as this one leaves
            if (can_load) begin
               push.load            = 1'b1;
               push.res.status      = ST_ENTRY;
               push.res.entry_value = rdata_ff;
               push.res.last        = (idx_nx == count_ff);
               if (idx_nx == count_ff) begin
                  state_in = S_IDLE;
               end else begin
                  mem_re = 1'b1;
                  idx_in = idx_nx;
               end
            end
         end
         S_SCAN: begin
            // kept never passes idx, so the compacting write never hits the next read
            if (rdata_ff != val_ff) begin
               mem_we  = 1'b1;
               kept_in = kept_ff + 1'b1;
            end
            if (idx_nx == count_ff) begin
               state_in = S_FIN;
            end else begin
               mem_re = 1'b1;
               idx_in = idx_nx;
            end
         end
         S_FIN: begin
            if (can_load) begin
               push.load          = 1'b1;
               count_in           = kept_ff;
               push.res.list_size = cnt_field(kept_ff);
               if (removed == '0) begin
                  push.res.status = ST_NOTFOUND;
               end else begin
                  push.res.status        = ST_REMOVED;
                  push.res.removed_count = cnt_field(removed);
               end
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         head_ff  <= '0;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         head_ff  <= head_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff   <= op_in;
      val_ff  <= val_in;
      idx_ff  <= idx_in;
      kept_ff <= kept_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         rdata_ff <= mem[mem_raddr];
      end
   end

   blire_rsp_reg u_rsp_reg (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .can_load (can_load),
      .rsp_chan (rsp_chan)
   );

endmodule

// ===== rtl/blire_rsp_reg.sv =====
// Response output register: holds one result until the sink takes it.
module blire_rsp_reg (
   input  logic                    clock,
   input  logic                    reset,
   input  blire_pkg::rsp_push_type push,
   output logic                    can_load,
   blire_rsp_if.source             rsp_chan
);
   import blire_pkg::*;

   logic    valid_ff, valid_in;
   rsp_type data_ff;

   assign can_load = !valid_ff || rsp_chan.ready;

   always_comb begin
      valid_in = valid_ff;
      if (push.load) begin
         valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.load) begin
         data_ff <= push.res;
      end
   end

   assign rsp_chan.valid         = valid_ff;
   assign rsp_chan.status        = data_ff.status;
   assign rsp_chan.entry_value   = data_ff.entry_value;
   assign rsp_chan.removed_count = data_ff.removed_count;
   assign rsp_chan.list_size     = data_ff.list_size;
   assign rsp_chan.last          = data_ff.last;

endmodule

// ===== rtl/blire_chk.sv =====
// Port-level checker for the list engine, bound to the top level.
`include "bounded_list_insert_remove_engine_unit_defines.svh"

module blire_chk (
   input logic                               clock,
   input logic                               reset,
   input logic                               req_valid,
   input logic                               req_ready,
   input logic                               rsp_valid,
   input logic                               rsp_ready,
   input logic [blire_pkg::ST_W-1:0]         rsp_status,
   input logic signed [blire_pkg::VAL_W-1:0] rsp_entry_value,
   input logic [blire_pkg::CNTF_W-1:0]       rsp_list_size,
   input logic                               rsp_last
);
   import blire_pkg::*;

   // A stalled response keeps its status, entry value and last flag.
   `BLIRE_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_status) && $stable(rsp_entry_value) && $stable(rsp_last))

   // Every accepted request leaves the engine busy, with ready low, after the accept.
   `BLIRE_ASSERT_NEXT(a_busy_after_req, clock, reset, req_valid && req_ready, !req_ready)

   // Only read-out produces results that are not the final one.
   `BLIRE_ASSERT_NOW(a_nonlast_is_entry, clock, reset, rsp_valid && !rsp_last, rsp_status == ST_ENTRY)

   // An empty status never reports a nonzero size.
   `BLIRE_ASSERT_NOW(a_empty_size, clock, reset, rsp_valid && rsp_status == ST_EMPTY, rsp_list_size == '0)

endmodule

bind bounded_list_insert_remove_engine_unit blire_chk u_blire_chk (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_chan.valid),
   .req_ready       (req_chan.ready),
   .rsp_valid       (rsp_chan.valid),
   .rsp_ready       (rsp_chan.ready),
   .rsp_status      (rsp_chan.status),
   .rsp_entry_value (rsp_chan.entry_value),
   .rsp_list_size   (rsp_chan.list_size),
   .rsp_last        (rsp_chan.last)
);

// ===== bench/tb_top.sv =====
// Testbench for the bounded list engine: directed and random traffic against a local list model.
`timescale 1ns / 100ps

module tb_top;
   import blire_pkg::*;

   logic clock;
   logic reset;

   blire_req_if req_chan();
   blire_rsp_if rsp_chan();

   bounded_list_insert_remove_engine_unit uut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan.sink),
      .rsp_chan (rsp_chan.source)
   );

   // local copy of the list: ring store, head position, entry count
   logic signed [VAL_W-1:0] list_store [DEPTH];
   int                      list_head;
   int                      list_count;

   rsp_type expected_rsps [$];
   rsp_type rsp_want;

   int send_idle_pct;
   int rcv_idle_pct;
   int errors;
   int n_requests;
   int n_responses;
   int n_full_rejects;
   int n_entries_read;
   int n_removes_hit;

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else begin
         rsp_chan.ready <= ($urandom_range(99) >= rcv_idle_pct);
      end
   end

   function automatic logic signed [VAL_W-1:0] entry_at(int k);
      return list_store[(list_head + k) % DEPTH];
   endfunction

   function automatic rsp_type make_rsp(logic [ST_W-1:0] st, logic signed [VAL_W-1:0] ev,
                                        int removed, logic is_last);
      rsp_type r;
      r.status        = st;
      r.entry_value   = ev;
      r.removed_count = CNTF_W'(removed);
      r.list_size     = CNTF_W'(list_count);
      r.last          = is_last;
      return r;
   endfunction

   // Updates the local list for one accepted request and queues the responses it causes.
   task automatic list_apply(input logic [OP_W-1:0] op, input logic signed [VAL_W-1:0] val);
      int kept;
      int i;
      logic signed [VAL_W-1:0] e;
      case (op)
         OP_INS_FRONT, OP_INS_BACK: begin
            if (list_count >= DEPTH) begin
               n_full_rejects++;
               expected_rsps.push_back(make_rsp(ST_FULL, '0, 0, 1'b1));
            end else begin
               if (op == OP_INS_FRONT) begin
                  list_head = (list_head + DEPTH - 1) % DEPTH;
                  list_store[list_head] = val;
               end else begin
                  list_store[(list_head + list_count) % DEPTH] = val;
               end
               list_count++;
               expected_rsps.push_back(make_rsp(ST_INSERTED, '0, 0, 1'b1));
            end
         end
         OP_READ_ALL: begin
            if (list_count == 0) begin
               expected_rsps.push_back(make_rsp(ST_EMPTY, '0, 0, 1'b1));
            end else begin
               for (i = 0; i < list_count; i++) begin
                  expected_rsps.push_back(make_rsp(ST_ENTRY, entry_at(i), 0,
                                                   i == list_count - 1));
               end
               n_entries_read += list_count;
            end
         end
         OP_REMOVE: begin
            if (list_count == 0) begin
               expected_rsps.push_back(make_rsp(ST_EMPTY, '0, 0, 1'b1));
            end else begin
               // compact in place, keeping order of survivors
               kept = 0;
               for (i = 0; i < list_count; i++) begin
                  e = entry_at(i);
                  if (e != val) begin
                     list_store[(list_head + kept) % DEPTH] = e;
                     kept++;
                  end
               end
               i = list_count - kept;
               list_count = kept;
               if (i == 0) begin
                  expected_rsps.push_back(make_rsp(ST_NOTFOUND, '0, 0, 1'b1));
               end else begin
                  n_removes_hit++;
                  expected_rsps.push_back(make_rsp(ST_REMOVED, '0, i, 1'b1));
               end
            end
         end
         OP_CLEAR: begin
            if (list_count == 0) begin
               expected_rsps.push_back(make_rsp(ST_EMPTY, '0, 0, 1'b1));
            end else begin
               list_count = 0;
               list_head  = 0;
               expected_rsps.push_back(make_rsp(ST_CLEARED, '0, 0, 1'b1));
            end
         end
         default: begin
            // unused opcodes: no response, no state change
         end
      endcase
   endtask

   task automatic send_op(input logic [OP_W-1:0] op, input logic signed [VAL_W-1:0] val);
      while ($urandom_range(99) < send_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid  <= 1'b1;
      req_chan.opcode <= op;
      req_chan.value  <= val;
      @(posedge clock);
      while (!req_chan.ready) begin
         @(posedge clock);
      end
      list_apply(op, val);
      n_requests++;
   endtask

   function automatic logic signed [VAL_W-1:0] pick_value();
      case ($urandom_range(3))
         0: return $urandom;
         1: return int'($urandom_range(6)) - 3;
         2: return (list_count != 0) ? entry_at($urandom_range(list_count - 1)) : $urandom;
         default: begin
            case ($urandom_range(3))
               0: return 32'h8000_0000;
               1: return 32'h7FFF_FFFF;
               2: return '0;
               default: return '1;
            endcase
         end
      endcase
   endfunction

   task automatic check_field(input string name, input logic [VAL_W-1:0] want,
                              input logic [VAL_W-1:0] got);
      if (want !== got) begin
         $error("%s mismatch: expected 0x%08h, got 0x%08h", name, want, got);
         errors++;
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         n_responses++;
         if (expected_rsps.size() == 0) begin
            $error("unexpected response transaction, status %0d", rsp_chan.status);
            errors++;
         end else begin
            rsp_want = expected_rsps.pop_front();
            check_field("status", VAL_W'(rsp_want.status), VAL_W'(rsp_chan.status));
            check_field("entry_value", rsp_want.entry_value, rsp_chan.entry_value);
            check_field("removed_count", VAL_W'(rsp_want.removed_count),
                        VAL_W'(rsp_chan.removed_count));
            check_field("list_size", VAL_W'(rsp_want.list_size),
                        VAL_W'(rsp_chan.list_size));
            check_field("last", VAL_W'(rsp_want.last), VAL_W'(rsp_chan.last));
         end
      end
   end

   task automatic test_empty_list();
      send_op(OP_READ_ALL, '0);
      send_op(OP_REMOVE, 32'sd5);
      send_op(OP_CLEAR, '0);
   endtask

   task automatic test_insert_extremes();
      send_op(OP_INS_BACK, 32'h7FFF_FFFF);
      send_op(OP_INS_FRONT, 32'h8000_0000);
      send_op(OP_INS_BACK, '0);
      send_op(OP_INS_FRONT, '1);
      send_op(OP_INS_BACK, 32'sd1);
      send_op(OP_READ_ALL, '0);
   endtask

   task automatic test_remove();
      send_op(OP_INS_BACK, 32'sd7);
      send_op(OP_INS_FRONT, 32'sd7);
      send_op(OP_INS_BACK, 32'sd7);
      send_op(OP_REMOVE, 32'sd7);
      send_op(OP_REMOVE, 32'sd12345);
      send_op(OP_REMOVE, 32'h8000_0000);
      send_op(OP_READ_ALL, '0);
   endtask

   task automatic test_unused_opcodes();
      send_op(3'd5, $urandom);
      send_op(3'd6, $urandom);
      send_op(3'd7, $urandom);
      send_op(OP_READ_ALL, '0);
   endtask

   task automatic test_clear();
      send_op(OP_CLEAR, '0);
      send_op(OP_READ_ALL, '0);
   endtask

   // fill to the limit from both ends so the ring wraps, then hit the full case
   task automatic test_full_list();
      while (list_count < DEPTH) begin
         send_op($urandom_range(1) ? OP_INS_FRONT : OP_INS_BACK, pick_value());
      end
      send_op(OP_INS_FRONT, $urandom);
      send_op(OP_INS_BACK, $urandom);
      send_op(OP_READ_ALL, '0);
      send_op(OP_REMOVE, entry_at(DEPTH / 2));
      send_op(OP_READ_ALL, '0);
      send_op(OP_CLEAR, '0);
   endtask

   task automatic test_random_traffic(input int snd_pct, input int rcv_pct, input int n_ops);
      int done;
      int r;
      logic signed [VAL_W-1:0] v;
      send_idle_pct = snd_pct;
      rcv_idle_pct  = rcv_pct;
      done = 0;
      while (done < n_ops) begin
         r = $urandom_range(99);
         if (r < 3) begin
            send_op(OP_W'($urandom_range(7, 5)), $urandom);
         end else if (r == 3) begin
            while (list_count < DEPTH) begin
               send_op($urandom_range(1) ? OP_INS_FRONT : OP_INS_BACK, pick_value());
               done++;
            end
            send_op($urandom_range(1) ? OP_INS_FRONT : OP_INS_BACK, pick_value());
            done++;
         end else if (r < 46) begin
            send_op($urandom_range(1) ? OP_INS_FRONT : OP_INS_BACK, pick_value());
            done++;
         end else if (r < 62) begin
            send_op(OP_READ_ALL, $urandom);
            done++;
         end else if (r < 92) begin
            if (list_count != 0 && $urandom_range(3) != 0) begin
               v = entry_at($urandom_range(list_count - 1));
            end else begin
               v = pick_value();
            end
            send_op(OP_REMOVE, v);
            done++;
         end else begin
            send_op(OP_CLEAR, $urandom);
            done++;
         end
      end
   endtask

   initial begin
      req_chan.valid  = 1'b0;
      req_chan.opcode = '0;
      req_chan.value  = '0;
      reset           = 1'b1;
      list_head       = 0;
      list_count      = 0;
      send_idle_pct   = 22;
      rcv_idle_pct    = 53;
      errors          = 0;
      n_requests      = 0;
      n_responses     = 0;
      n_full_rejects  = 0;
      n_entries_read  = 0;
      n_removes_hit   = 0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_empty_list();
      test_insert_extremes();
      test_remove();
      test_unused_opcodes();
      test_clear();
      test_full_list();
      test_random_traffic(22, 53, 140);
      test_random_traffic(53, 22, 140);
      test_random_traffic(0, 0, 140);

      req_chan.valid <= 1'b0;
      while (expected_rsps.size() != 0) begin
         @(posedge clock);
      end
      repeat (DEPTH + 10) @(posedge clock);

      $display("Sent %0d requests, checked %0d responses: %0d entries read out,",
               n_requests, n_responses, n_entries_read);
      $display("%0d removes that hit, %0d inserts rejected on a full list.",
               n_removes_hit, n_full_rejects);
      if (errors == 0) begin
         $display("bounded_list_insert_remove_engine_unit test passed");
      end else begin
         $display("bounded_list_insert_remove_engine_unit test failed");
      end
      $finish;
   end

   initial begin
      #10_000_000;
      $display("bounded_list_insert_remove_engine_unit test failed");
      $finish;
   end

endmodule

// ===== bounded_list_insert_remove_engine_unit.f =====
+incdir+rtl
rtl/blire_pkg.sv
rtl/blire_ifs.sv
rtl/blire_rsp_reg.sv
rtl/bounded_list_insert_remove_engine_unit.sv
rtl/blire_chk.sv
bench/tb_top.sv
